// File: hdl/cbfp_pkg.sv
// Package for the clamped bit-field packer.
// Field widths and byte constants shared by the interfaces and all modules.
// No dependencies.
`default_nettype none

package cbfp_pkg;

    localparam int FIELD_W  = 32;  // width of value, min and max
    localparam int BITS_W   = 6;   // width of the field_bits port
    localparam int BYTE_W   = 8;
    localparam int PEND_W   = 3;   // index of a bit inside one byte

endpackage

`default_nettype wire

// File: hdl/cbfp_if.sv
// Valid/ready channel interfaces of the clamped bit-field packer.
// cbfp_in_if carries one field item, cbfp_out_if one packed byte.
// Depends on cbfp_pkg.
`default_nettype none

interface cbfp_in_if import cbfp_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] field_value;
    logic signed [FIELD_W-1:0] field_min;
    logic signed [FIELD_W-1:0] field_max;
    logic [BITS_W-1:0]         field_bits;
    logic                      last_field;

    modport source (output valid, field_value, field_min, field_max, field_bits,
                    last_field, input ready);
    modport sink   (input valid, field_value, field_min, field_max, field_bits,
                    last_field, output ready);
endinterface

interface cbfp_out_if import cbfp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              last_byte;

    modport source (output valid, out_byte, last_byte, input ready);
    modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

`default_nettype wire

// File: hdl/clamped_bit_field_packer_top.sv
// Top level of the clamped bit-field packer.
// Instantiates cbfp_clamp and cbfp_serializer; depends on cbfp_pkg, cbfp_if.
//
// Usage:
//   in_ch  : one field item per handshake (value, min, max, width, last flag).
//            The value is clamped to [min, max], min is subtracted modulo 2^32,
//            and the result is masked to min(field_bits, MAX_FIELD_WIDTH) bits.
//   out_ch : one packed byte per handshake, earliest bits in the low positions;
//            last_byte marks the final byte of a packet (zero-padded flush).
//   Path:    an item is registered in the clamp stage, then loaded into the bit
//            accumulator, and its first byte is then registered in the output
//            register.
//   Throughput: the output register sends one byte a cycle while out_ch.ready
//            is high. The next item loads in the cycle the previous one's last
//            full byte goes out. A last field with an empty flush emits nothing.
//   Reset:   rst_n clears the pending bits, count and all valid flags.
//   Stall:   while out_ch.ready is low the output byte holds, the accumulator
//            keeps its bits, and in_ch.ready drops once the clamp register
//            is full.
`default_nettype none

module clamped_bit_field_packer_top import cbfp_pkg::*; #(
    parameter int MAX_FIELD_WIDTH = 32
) (
    input  wire logic clk,
    input  wire logic rst_n,
    cbfp_in_if.sink   in_ch,
    cbfp_out_if.source out_ch
);

    // width of a saturated bit count, 0..MAX_FIELD_WIDTH
    localparam int BITS_N = $clog2(MAX_FIELD_WIDTH + 1);

    logic                       s1_valid;
    logic                       s1_ready;
    logic [MAX_FIELD_WIDTH-1:0] s1_val;
    logic [BITS_N-1:0]          s1_bits;
    logic                       s1_last;

    // clamp, offset and mask; one registered field
    cbfp_clamp #(
        .W      (MAX_FIELD_WIDTH),
        .BITS_N (BITS_N)
    ) u_clamp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .s1_valid (s1_valid),
        .s1_ready (s1_ready),
        .s1_val   (s1_val),
        .s1_bits  (s1_bits),
        .s1_last  (s1_last)
    );

    // bit accumulator and byte output register
    cbfp_serializer #(
        .W      (MAX_FIELD_WIDTH),
        .BITS_N (BITS_N)
    ) u_serializer (
        .clk      (clk),
        .rst_n    (rst_n),
        .s1_valid (s1_valid),
        .s1_ready (s1_ready),
        .s1_val   (s1_val),
        .s1_bits  (s1_bits),
        .s1_last  (s1_last),
        .out_ch   (out_ch)
    );

endmodule

`default_nettype wire

// File: hdl/cbfp_clamp.sv
// Input stage: clamps, offsets and masks one field, result held in a register.
// Depends on cbfp_pkg and cbfp_in_if.
`default_nettype none

module cbfp_clamp import cbfp_pkg::*; #(
    parameter int W      = 32,
    parameter int BITS_N = 6
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    cbfp_in_if.sink                in_ch,
    output logic                   s1_valid,
    input  wire logic              s1_ready,
    output logic [W-1:0]           s1_val,
    output logic [BITS_N-1:0]      s1_bits,
    output logic                   s1_last
);

    logic                  s1_valid_reg;
    logic [W-1:0]          s1_val_reg;
    logic [BITS_N-1:0]     s1_bits_reg;
    logic                  s1_last_reg;

    logic signed [FIELD_W-1:0] clamped;
    logic [FIELD_W-1:0]        diff;
    logic [BITS_N-1:0]         bits_sat;
    logic [W:0]                mask_wide;
    logic [W-1:0]              val_next;
    logic                      take;

    always_comb
    begin
        // Inverted bounds fall out of this order: below min wins.
        if (in_ch.field_value < in_ch.field_min)
            clamped = in_ch.field_min;
        else if (in_ch.field_value > in_ch.field_max)
            clamped = in_ch.field_max;
        else
            clamped = in_ch.field_value;
        diff = FIELD_W'(clamped - in_ch.field_min);

        if (in_ch.field_bits > BITS_W'(W))
            bits_sat = BITS_N'(W);
        else
            bits_sat = BITS_N'(in_ch.field_bits);

        mask_wide = ((W+1)'(1) << bits_sat) - (W+1)'(1);
        val_next  = diff[W-1:0] & mask_wide[W-1:0];
    end

    assign in_ch.ready = !s1_valid_reg || s1_ready;
    assign take        = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ch.ready)
            s1_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_val_reg  <= val_next;
            s1_bits_reg <= bits_sat;
            s1_last_reg <= in_ch.last_field;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_val   = s1_val_reg;
    assign s1_bits  = s1_bits_reg;
    assign s1_last  = s1_last_reg;

    a_masked: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> ((s1_val_reg >> s1_bits_reg) == '0))
        else $error("held field has bits above its width");

    a_width: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (s1_bits_reg <= BITS_N'(W)))
        else $error("held field width above maximum");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_ready) |=> (s1_valid_reg && $stable(s1_val_reg)))
        else $error("stalled field lost or changed");

endmodule

`default_nettype wire

// File: hdl/cbfp_serializer.sv
// Bit accumulator and byte output register of the clamped bit-field packer.
// Appends fields LSB-first, emits one byte a cycle unless stalled, flushes on last.
// Depends on cbfp_pkg and cbfp_out_if.
`default_nettype none

module cbfp_serializer import cbfp_pkg::*; #(
    parameter int W      = 32,
    parameter int BITS_N = 6
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s1_valid,
    output logic                   s1_ready,
    input  wire logic [W-1:0]      s1_val,
    input  wire logic [BITS_N-1:0] s1_bits,
    input  wire logic              s1_last,
    cbfp_out_if.source             out_ch
);

    localparam int ACC_W = W + BYTE_W - 1;
    localparam int CNT_W = $clog2(ACC_W + 1);

    logic [ACC_W-1:0]  acc_reg, acc_next, acc_e;
    logic [CNT_W-1:0]  cnt_reg, cnt_next, cnt_e;
    logic              flush_reg, flush_next, flush_e;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              out_last_reg, out_last_next;
    logic              out_free, emit, load, full_byte;

    always_comb
    begin
        out_free  = !out_valid_reg || out_ch.ready;
        full_byte = cnt_reg >= CNT_W'(BYTE_W);
        // flush_reg implies bits remain, so a flush always has a byte to send
        emit      = out_free && (full_byte || flush_reg);

        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        acc_e          = acc_reg;
        cnt_e          = cnt_reg;
        flush_e        = flush_reg;

        if (emit)
        begin
            out_byte_next  = acc_reg[BYTE_W-1:0];
            out_last_next  = flush_reg && (cnt_reg <= CNT_W'(BYTE_W));
            out_valid_next = 1'b1;
            acc_e          = acc_reg >> BYTE_W;
            cnt_e          = full_byte ? cnt_reg - CNT_W'(BYTE_W) : '0;
            flush_e        = flush_reg && (cnt_e != '0);
        end

        // next field enters while the final byte of this one goes out
        s1_ready = !flush_e && (cnt_e < CNT_W'(BYTE_W));
        load     = s1_valid && s1_ready;

        acc_next   = acc_e;
        cnt_next   = cnt_e;
        flush_next = flush_e;
        if (load)
        begin
            acc_next   = acc_e | (ACC_W'(s1_val) << cnt_e[PEND_W-1:0]);
            cnt_next   = cnt_e + CNT_W'(s1_bits);
            flush_next = s1_last && (cnt_next != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            cnt_reg       <= '0;
            flush_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            flush_reg     <= flush_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.out_byte  = out_byte_reg;
    assign out_ch.last_byte = out_last_reg;

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(ACC_W))
        else $error("bit count out of range");

    a_flush_bits: assert property (@(posedge clk) disable iff (!rst_n)
        flush_reg |-> (cnt_reg != '0))
        else $error("flush pending with no bits");

    a_clean_acc: assert property (@(posedge clk) disable iff (!rst_n)
        (acc_reg >> cnt_reg) == '0)
        else $error("accumulator holds bits above count");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && flush_reg && (cnt_reg <= CNT_W'(BYTE_W)) && !load)
        |=> (cnt_reg == '0 && !flush_reg))
        else $error("state not cleared after last byte");

endmodule

`default_nettype wire

// File: test/clamped_bit_field_packer_top_tb.sv
// Testbench for clamped_bit_field_packer_top: directed table, then random packets.
// Checks every packed byte against a built-in bit-stream predictor.
// Depends on cbfp_pkg, cbfp_if and the packer RTL.
`timescale 1ns / 1ps
`default_nettype none

module clamped_bit_field_packer_top_tb import cbfp_pkg::*; ();

    localparam int MAX_W         = 32;
    localparam int MAX_BYTES     = 5;     // 7 pending + 32 new bits, then flush
    localparam int PREDICTED     = -1;    // table row with no typed-in bytes
    localparam int ITEMS_PER_RUN = 44;    // minimum random items per idling setting
    localparam int REPORT_LIMIT  = 10;

    localparam logic signed [FIELD_W-1:0] S_MIN = 32'sh8000_0000;
    localparam logic signed [FIELD_W-1:0] S_MAX = 32'sh7FFF_FFFF;

    // One field as the sender presents it.
    typedef struct {
        logic signed [FIELD_W-1:0] value;
        logic signed [FIELD_W-1:0] lo_bound;
        logic signed [FIELD_W-1:0] hi_bound;
        logic [BITS_W-1:0]         width;
        logic                      last;
    } field_item_t;

    // One packed byte as the receiver sees it.
    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              last;
    } packed_byte_t;

    // Directed row: field plus, where obvious, the bytes it must produce.
    typedef struct {
        field_item_t            f;
        int                     n_typed;
        logic [4:0][BYTE_W-1:0] typed;
    } stim_row_t;

    logic clk;
    logic rst_n;

    cbfp_in_if  in_ch ();
    cbfp_out_if out_ch ();

    clamped_bit_field_packer_top #(
        .MAX_FIELD_WIDTH(MAX_W)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .out_ch(out_ch)
    );

    // Predictor state: bits waiting for a full byte, low-aligned.
    logic [6:0]   stream_bits;
    logic [2:0]   stream_count;
    packed_byte_t byte_q[$];      // bytes still owed by the packer
    int           errors;
    int           tx_idle_pct;
    int           rx_stall_pct;

    // Rows typed in only start from an empty bit stream (after reset or a
    // last field), so their bytes follow from the clamp alone.
    stim_row_t dir_rows[$] = '{
        // plain byte right after reset
        '{'{32'sd5, 32'sd0, 32'sd255, 6'd8, 1'b1}, 1, 40'h00_0000_0005},
        // full range: max value packs to all ones, flush lands on a byte edge
        '{'{S_MAX, S_MIN, S_MAX, 6'd32, 1'b1}, 4, 40'h00_FFFF_FFFF},
        '{'{S_MIN, S_MIN, S_MAX, 6'd32, 1'b1}, 4, 40'h00_0000_0000},
        // clamp at the top and at the bottom
        '{'{32'sd1000, 32'sd0, 32'sd100, 6'd8, 1'b1}, 1, 40'h00_0000_0064},
        '{'{-32'sd50, -32'sd10, 32'sd10, 6'd8, 1'b1}, 1, 40'h00_0000_0000},
        // inverted bounds: below min takes min, anything else takes max
        '{'{32'sd3, 32'sd10, 32'sd5, 6'd8, 1'b1}, 1, 40'h00_0000_0000},
        '{'{32'sd12, 32'sd10, 32'sd5, 6'd8, 1'b1}, 1, 40'h00_0000_00FB},
        '{'{S_MAX, S_MAX, S_MIN, 6'd32, 1'b1}, 4, 40'h00_0000_0001},
        // zero width on an empty stream: nothing comes out
        '{'{32'sd123, 32'sd0, 32'sd255, 6'd0, 1'b1}, 0, 40'h0},
        // oversized widths fall back to 32 bits
        '{'{S_MAX, S_MIN, S_MAX, 6'd63, 1'b1}, 4, 40'h00_FFFF_FFFF},
        '{'{-32'sd1, S_MIN, S_MAX, 6'd33, 1'b1}, 4, 40'h00_7FFF_FFFF},
        // single bit flushed zero-padded
        '{'{32'sd1, 32'sd0, 32'sd1, 6'd1, 1'b1}, 1, 40'h00_0000_0001},
        // fields that fill one byte exactly; the byte-edge flush marks a full byte
        '{'{32'sd5, 32'sd0, 32'sd7, 6'd3, 1'b0}, PREDICTED, 40'h0},
        '{'{32'sd2, 32'sd0, 32'sd7, 6'd3, 1'b0}, PREDICTED, 40'h0},
        '{'{32'sd3, 32'sd0, 32'sd3, 6'd2, 1'b1}, PREDICTED, 40'h0},
        // 7 pending bits plus 32 twice: the five-byte worst case at the end
        '{'{32'sd9, 32'sd0, 32'sd100, 6'd7, 1'b0}, PREDICTED, 40'h0},
        '{'{S_MAX, S_MIN, S_MAX, 6'd32, 1'b0}, PREDICTED, 40'h0},
        '{'{-32'sd1, S_MIN, S_MAX, 6'd40, 1'b1}, PREDICTED, 40'h0},
        // zero width in mid packet, then a flush on a byte edge
        '{'{32'sd77, 32'sd0, 32'sd255, 6'd0, 1'b0}, PREDICTED, 40'h0},
        '{'{32'sd6, 32'sd0, 32'sd15, 6'd4, 1'b0}, PREDICTED, 40'h0},
        '{'{32'sd300, -32'sd300, 32'sd300, 6'd12, 1'b1}, PREDICTED, 40'h0},
        // degenerate range and negative bounds
        '{'{32'sd0, 32'sd0, 32'sd0, 6'd5, 1'b0}, PREDICTED, 40'h0},
        '{'{-32'sd7, -32'sd8, -32'sd1, 6'd3, 1'b1}, PREDICTED, 40'h0}
    };

    // Clock: 10 ns period.
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Fixed limit; the slowest correct run is well under a tenth of this.
    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic void flag_error(input string msg);
        errors++;
        if (errors <= REPORT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    // Clamp, rebase to the lower bound, mask and append the field to the bit
    // stream. Returns the bytes the packer owes for this item.
    function automatic int predict_bytes(input field_item_t f,
                                         output packed_byte_t res [MAX_BYTES]);
        logic signed [FIELD_W-1:0] clamped;
        logic [FIELD_W-1:0]        rebased;
        logic [63:0]               acc;
        int unsigned               width;
        int unsigned               total;
        int                        n;
        n = 0;
        for (int i = 0; i < MAX_BYTES; i++)
            res[i] = '{8'h00, 1'b0};
        width = (f.width > MAX_W) ? MAX_W : f.width;
        // lower bound wins when the bounds are inverted
        if (f.value < f.lo_bound)
            clamped = f.lo_bound;
        else if (f.value > f.hi_bound)
            clamped = f.hi_bound;
        else
            clamped = f.value;
        rebased = clamped - f.lo_bound;               // wraps modulo 2^32
        if (width < MAX_W)
            rebased &= (32'h1 << width) - 32'h1;
        acc   = {57'b0, stream_bits} | ({32'b0, rebased} << stream_count);
        total = stream_count + width;
        while (total >= 8)
        begin
            res[n] = '{acc[7:0], 1'b0};
            n++;
            acc   = acc >> 8;
            total = total - 8;
        end
        if (f.last)
        begin
            if (total > 0)
            begin
                res[n] = '{acc[7:0], 1'b1};
                n++;
            end
            else if (n > 0)
            begin
                res[n-1].last = 1'b1;                 // flush on a byte edge
            end
            stream_bits  = '0;
            stream_count = '0;
        end
        else
        begin
            stream_bits  = acc[6:0];
            stream_count = total[2:0];
        end
        return n;
    endfunction

    function automatic field_item_t random_field(input bit is_last);
        field_item_t f;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 15)
        begin
            f.lo_bound = $urandom;                    // either order
            f.hi_bound = $urandom;
        end
        else if (pick < 25)
        begin
            f.lo_bound = S_MIN;
            f.hi_bound = S_MAX;
        end
        else
        begin
            f.lo_bound = $urandom_range(0, 2097152) - 1048576;
            f.hi_bound = f.lo_bound + $urandom_range(0, 4095);
            if (pick < 33)
                {f.lo_bound, f.hi_bound} = {f.hi_bound, f.lo_bound};
        end
        pick = $urandom_range(99);
        if (pick < 30)
            f.value = $urandom;
        else if (pick < 45)
            f.value = f.lo_bound - $urandom_range(0, 3);
        else if (pick < 60)
            f.value = f.hi_bound + $urandom_range(0, 3);
        else
            f.value = f.lo_bound + $urandom_range(0, 4095);
        pick = $urandom_range(99);
        if (pick < 8)
            f.width = 6'd0;
        else if (pick < 16)
            f.width = BITS_W'($urandom_range(33, 63));
        else if (pick < 40)
            f.width = BITS_W'($urandom_range(1, 8));
        else
            f.width = BITS_W'($urandom_range(1, 32));
        f.last = is_last;
        return f;
    endfunction

    // Present one field, idling at random first; returns at the accepting edge.
    // valid stays high afterwards so back-to-back items never toggle it.
    task automatic send_field(input field_item_t f);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.field_value <= f.value;
        in_ch.field_min   <= f.lo_bound;
        in_ch.field_max   <= f.hi_bound;
        in_ch.field_bits  <= f.width;
        in_ch.last_field  <= f.last;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    task automatic send_random_field(input bit is_last);
        field_item_t  f;
        packed_byte_t res [MAX_BYTES];
        int           n;
        f = random_field(is_last);
        send_field(f);
        n = predict_bytes(f, res);
        for (int i = 0; i < n; i++)
            byte_q.push_back(res[i]);
    endtask

    // Sender holds off until the packer has delivered everything owed.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (byte_q.size() != 0);
    endtask

    // Receiver: checks each accepted byte, then picks next cycle's ready.
    initial
    begin : byte_monitor
        packed_byte_t want;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                if (byte_q.size() == 0)
                begin
                    flag_error($sformatf("unexpected byte %02h last=%0b",
                                         out_ch.out_byte, out_ch.last_byte));
                end
                else
                begin
                    want = byte_q.pop_front();
                    if (out_ch.out_byte !== want.data || out_ch.last_byte !== want.last)
                        flag_error($sformatf("byte exp %02h last=%0b, got %02h last=%0b",
                                             want.data, want.last,
                                             out_ch.out_byte, out_ch.last_byte));
                end
            end
            out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Main stimulus.
    initial
    begin : stimulus
        stim_row_t    row;
        packed_byte_t res [MAX_BYTES];
        int           n;
        int           sent;
        int           pkt_len;
        int           guard;

        errors            = 0;
        stream_bits       = '0;
        stream_count      = '0;
        tx_idle_pct       = 23;
        rx_stall_pct      = 51;
        rst_n             = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.field_value = '0;
        in_ch.field_min   = '0;
        in_ch.field_max   = '0;
        in_ch.field_bits  = '0;
        in_ch.last_field  = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table. Typed rows still run the predictor so its bit
        // stream stays in step with the packer.
        for (int r = 0; r < dir_rows.size(); r++)
        begin
            row = dir_rows[r];
            send_field(row.f);
            n = predict_bytes(row.f, res);
            if (row.n_typed != PREDICTED)
            begin
                n = row.n_typed;
                for (int i = 0; i < n; i++)
                    res[i] = '{row.typed[i], row.f.last && (i == n - 1)};
            end
            for (int i = 0; i < n; i++)
                byte_q.push_back(res[i]);
        end

        // Drain fully before the random part.
        wait_drained();

        // Random packets under three idling settings: sender-light, then
        // receiver-light, then none. Packets are 1 to 6 fields, last one flagged.
        for (int ph = 0; ph < 3; ph++)
        begin
            tx_idle_pct  = (ph == 0) ? 23 : (ph == 1) ? 51 : 0;
            rx_stall_pct = (ph == 0) ? 51 : (ph == 1) ? 23 : 0;
            sent = 0;
            while (sent < ITEMS_PER_RUN)
            begin
                pkt_len = $urandom_range(1, 6);
                for (int k = 0; k < pkt_len; k++)
                begin
                    send_random_field(k == pkt_len - 1);
                    sent++;
                end
            end
            if (ph == 0)
                wait_drained();
        end

        // Open packet left over from noise is impossible here: every random
        // packet ends in a last field, so the stream is empty at this point.
        in_ch.valid <= 1'b0;
        guard = 0;
        while (byte_q.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (10) @(posedge clk);
        if (byte_q.size() != 0)
            flag_error($sformatf("%0d bytes never arrived", byte_q.size()));

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
